### src/stvf_pkg.sv
// shared types and constants for the srv6 tag/segment acl filter
`default_nettype none

package stvf_pkg;

  // packet byte positions and header codes
  localparam int unsigned PosW = 7;
  localparam logic [PosW-1:0] PktMinLen   = 7'd64;
  localparam logic [PosW-1:0] PosVersion  = 7'd0;
  localparam logic [PosW-1:0] PosNextHdr  = 7'd6;
  localparam logic [PosW-1:0] PosRtType   = 7'd42;
  localparam logic [PosW-1:0] PosTagHi    = 7'd46;
  localparam logic [PosW-1:0] PosTagLo    = 7'd47;
  localparam logic [PosW-1:0] PosSegFirst = 7'd48;
  localparam logic [PosW-1:0] PosFullPrev = 7'd63;

  localparam logic [3:0] Ipv6Version = 4'd6;
  localparam logic [7:0] NhRouting   = 8'd43;
  localparam logic [7:0] RtTypeSrh   = 8'd4;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAG     = 2'd0,
    CFG_SEG_HI  = 2'd1,
    CFG_SEG_LO  = 2'd2
  } cfg_idx_e;

  typedef logic [PosW-1:0] pos_t;

  // one classified byte as handed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hdr_bad;   // version, next header or routing type mismatch
    logic       seg_miss;  // segment byte differs from configured address
    logic       tag_hi;    // byte is the upper tag byte
    logic       tag_lo;    // byte is the lower tag byte
    logic       full;      // at least 64 bytes seen including this one
  } cls_t;

  // queue head toward the back part
  typedef struct packed {
    logic valid;
    cls_t item;
  } q_head_t;

endpackage

`default_nettype wire

### src/srv6_tag_segment_acl_filter.sv
// top level of the srv6 routing header tag/segment acl filter
//
// channel   | direction | beat contents
// s_axis    | in        | tdata[7:0] packet_byte, tlast end_of_packet
// m_axis    | out       | tdata[0] drop_packet, tdata[7:1] zero
// cfg       | in        | cfg_idx_i 0 tag, 1 segment high, 2 segment low
//
// takes one packet byte per cycle while the queue has room
// one verdict per packet, valid once the last beat has left the queue and reached the output register
// a last beat waits at the queue head while the output register holds a verdict not yet taken
// the front and the back each stall on their own; output stall backs up the queue
// reset clears position, packet state, queue and output; no clearing pass

`default_nettype none

module srv6_tag_segment_acl_filter #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] packet_byte
  input  wire logic                          s_axis_tlast,   // end_of_packet
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [0] drop_packet
  input  wire logic                          cfg_we_i,
  input  wire logic [stvf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [63:0]                   cfg_data_i
);

  logic [15:0]       tag_cfg_q;
  logic [63:0]       seg_hi_q;
  logic [63:0]       seg_lo_q;
  logic              push;
  logic              pop;
  logic              q_full;
  stvf_pkg::cls_t    cls;
  stvf_pkg::q_head_t head;
  logic              out_drop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_cfg_q <= '0;
      seg_hi_q  <= '0;
      seg_lo_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stvf_pkg::CFG_TAG:    tag_cfg_q <= cfg_data_i[15:0];
        stvf_pkg::CFG_SEG_HI: seg_hi_q  <= cfg_data_i;
        stvf_pkg::CFG_SEG_LO: seg_lo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input handshake
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  stvf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .seg_hi_i (seg_hi_q),
    .seg_lo_i (seg_lo_q),
    .cls_o    (cls)
  );

  stvf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (cls),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  stvf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .tag_cfg_i   (tag_cfg_q),
    .out_valid_o (m_axis_tvalid),
    .out_drop_o  (out_drop),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {7'b0, out_drop};

  // checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid) else $error("pop from empty queue");

  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.item.last) |=> m_axis_tvalid) else $error("verdict not presented");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output overwritten while stalled");

endmodule

`default_nettype wire

### src/stvf_front.sv
// front part: byte position tracking and per-byte classification
`default_nettype none

module stvf_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,      // beat accepted this cycle
  input  wire logic [7:0]           data_i,
  input  wire logic                 last_i,
  input  wire logic [63:0]          seg_hi_i,
  input  wire logic [63:0]          seg_lo_i,
  output stvf_pkg::cls_t            cls_o
);

  stvf_pkg::pos_t pos_q, pos_d;
  logic           in_hdr;
  logic           in_seg;
  logic [3:0]     seg_idx;
  logic [63:0]    seg_word;
  logic [2:0]     byte_sel;
  logic [7:0]     exp_byte;

  // positions below 64 are examined, later ones ignored
  assign in_hdr  = (pos_q < stvf_pkg::PktMinLen);
  assign in_seg  = in_hdr && (pos_q >= stvf_pkg::PosSegFirst);
  assign seg_idx = pos_q[3:0];

  // expected segment byte, first byte most significant
  assign seg_word = seg_idx[3] ? seg_lo_i : seg_hi_i;
  assign byte_sel = 3'd7 - seg_idx[2:0];
  assign exp_byte = seg_word[{byte_sel, 3'b000} +: 8];

  // classify the incoming byte
  always_comb begin
    cls_o.data     = data_i;
    cls_o.last     = last_i;
    cls_o.hdr_bad  = ((pos_q == stvf_pkg::PosVersion) && (data_i[7:4] != stvf_pkg::Ipv6Version))
                  || ((pos_q == stvf_pkg::PosNextHdr) && (data_i != stvf_pkg::NhRouting))
                  || ((pos_q == stvf_pkg::PosRtType) && (data_i != stvf_pkg::RtTypeSrh));
    cls_o.seg_miss = in_seg && (data_i != exp_byte);
    cls_o.tag_hi   = (pos_q == stvf_pkg::PosTagHi);
    cls_o.tag_lo   = (pos_q == stvf_pkg::PosTagLo);
    cls_o.full     = (pos_q >= stvf_pkg::PosFullPrev);
  end

  // saturating position counter, cleared after the last beat
  always_comb begin
    pos_d = pos_q;
    if (push_i) begin
      if (last_i) begin
        pos_d = '0;
      end else if (in_hdr) begin
        pos_d = pos_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

### src/stvf_queue.sv
// short queue between front and back parts
`default_nettype none

module stvf_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire stvf_pkg::cls_t  item_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output stvf_pkg::q_head_t    head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  stvf_pkg::cls_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o      = (cnt_q == CntMax);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/stvf_back.sv
// back part: per-packet accumulation and verdict register
`default_nettype none

module stvf_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stvf_pkg::q_head_t head_i,
  output logic                   pop_o,
  input  wire logic [15:0]       tag_cfg_i,
  output logic                   out_valid_o,
  output logic                   out_drop_o,
  input  wire logic              out_ready_i
);

  logic        hv_q, hv_d;
  logic [15:0] tag_q, tag_d;
  logic        seg_q, seg_d;
  logic        verdict;
  logic        out_valid_q;
  logic        out_drop_q;

  // non-last beats always drain; a last beat needs room in the output register
  assign pop_o = head_i.valid && (!head_i.item.last || !out_valid_q || out_ready_i);

  // state updated by the head beat
  always_comb begin
    hv_d  = hv_q && !head_i.item.hdr_bad;
    seg_d = seg_q && !head_i.item.seg_miss;
    tag_d = tag_q;
    if (head_i.item.tag_hi) begin
      tag_d[15:8] = head_i.item.data;
    end
    if (head_i.item.tag_lo) begin
      tag_d[7:0] = head_i.item.data;
    end
  end

  assign verdict = hv_d && head_i.item.full && ((tag_d == tag_cfg_i) || seg_d);

  // packet state, cleared after each last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b1;
      tag_q <= '0;
      seg_q <= 1'b1;
    end else if (pop_o) begin
      if (head_i.item.last) begin
        hv_q  <= 1'b1;
        tag_q <= '0;
        seg_q <= 1'b1;
      end else begin
        hv_q  <= hv_d;
        tag_q <= tag_d;
        seg_q <= seg_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && head_i.item.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.item.last) begin
      out_drop_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_drop_o  = out_drop_q;

endmodule

`default_nettype wire

### verif/srv6_tag_segment_acl_filter_tb.sv
// self-checking testbench for the srv6 routing header tag/segment acl filter
`timescale 1ns / 1ps

module srv6_tag_segment_acl_filter_tb;

  localparam int unsigned     CycleLimit   = 400000;
  localparam int unsigned     LongHold     = 300;
  localparam int unsigned     SettleCycles = 20;
  localparam logic [stvf_pkg::CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  // how a generated packet departs from a well-formed srv6 packet
  typedef enum int {
    FAULT_NONE,
    FAULT_VERSION,
    FAULT_NEXT_HDR,
    FAULT_RT_TYPE,
    FAULT_NOISE
  } fault_e;

  // how the first segment relates to the configured address
  typedef enum int {
    SEG_RANDOM,
    SEG_MATCH,
    SEG_NEAR
  } seg_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;   // [7:0] packet_byte
  logic                          s_axis_tlast  = 1'b0; // end_of_packet
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;         // [0] drop_packet, [7:1] zero
  logic                          cfg_we_i      = 1'b0;
  logic [stvf_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [63:0]                   cfg_data_i    = '0;

  // beats waiting to be sent and verdicts waiting to arrive
  pkt_beat_t pkt_q[$];
  logic      verdict_q[$];

  // filter configuration as the block holds it
  logic [15:0] cfg_tag    = '0;
  logic [63:0] cfg_seg_hi = '0;
  logic [63:0] cfg_seg_lo = '0;

  // per-packet state of the filter
  logic [stvf_pkg::PosW-1:0] pkt_pos = '0;
  logic                      hdr_ok  = 1'b1;
  logic [15:0]               pkt_tag = '0;
  logic                      seg_ok  = 1'b1;

  // idling and stall control
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 80;
  int unsigned stall_token   = 0;
  int unsigned stall_seen    = 0;
  int unsigned stall_left    = 0;

  // bookkeeping
  int unsigned cycles        = 0;
  int unsigned err_count     = 0;
  int unsigned bytes_queued  = 0;
  int unsigned pkts_queued   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned verdicts_seen = 0;
  int unsigned drops_seen    = 0;
  int unsigned cfg_writes    = 0;
  logic        want_drop;

  srv6_tag_segment_acl_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // run-length guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // configured address byte k of the first segment, first byte most significant
  function automatic logic [7:0] seg_cfg_byte(input logic [3:0] k);
    logic [63:0] word;
    word = k[3] ? cfg_seg_lo : cfg_seg_hi;
    return word[8*(7-k[2:0]) +: 8];
  endfunction

  // advance the filter by one accepted byte, queue the verdict on the last one
  function automatic void filter_byte(input logic [7:0] b, input logic last);
    if (pkt_pos < stvf_pkg::PktMinLen) begin
      if (pkt_pos == stvf_pkg::PosVersion && b[7:4] != stvf_pkg::Ipv6Version) hdr_ok = 1'b0;
      if (pkt_pos == stvf_pkg::PosNextHdr && b != stvf_pkg::NhRouting) hdr_ok = 1'b0;
      if (pkt_pos == stvf_pkg::PosRtType && b != stvf_pkg::RtTypeSrh) hdr_ok = 1'b0;
      if (pkt_pos == stvf_pkg::PosTagHi) pkt_tag[15:8] = b;
      if (pkt_pos == stvf_pkg::PosTagLo) pkt_tag[7:0] = b;
      if (pkt_pos >= stvf_pkg::PosSegFirst &&
          b != seg_cfg_byte(4'(pkt_pos - stvf_pkg::PosSegFirst)))
        seg_ok = 1'b0;
      pkt_pos++;
    end
    if (last) begin
      verdict_q.push_back(hdr_ok && pkt_pos >= stvf_pkg::PktMinLen &&
                          (pkt_tag == cfg_tag || seg_ok));
      pkt_pos = '0;
      hdr_ok  = 1'b1;
      pkt_tag = '0;
      seg_ok  = 1'b1;
    end
  endfunction

  // sender: offers queued beats, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        filter_byte(s_axis_tdata, s_axis_tlast);
        void'(pkt_q.pop_front());
        bytes_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pkt_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pkt_q[0].data;
          s_axis_tlast  <= pkt_q[0].last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks verdicts, stalls at random or for a long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("drop_packet arrived with no verdict pending, actual %0d", m_axis_tdata[0]);
          err_count++;
        end else begin
          want_drop = verdict_q.pop_front();
          verdicts_seen++;
          if (m_axis_tdata[0]) drops_seen++;
          if (m_axis_tdata[0] !== want_drop) begin
            $error("drop_packet expected %0d actual %0d", want_drop, m_axis_tdata[0]);
            err_count++;
          end
        end
      end
      if (stall_token != stall_seen) begin
        stall_seen = stall_token;
        stall_left = LongHold;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // register write, one per cycle; the model takes it at once since the block is idle
  task automatic write_reg(input logic [stvf_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    cfg_writes++;
    case (idx)
      stvf_pkg::CFG_TAG:    cfg_tag    = val[15:0];
      stvf_pkg::CFG_SEG_HI: cfg_seg_hi = val;
      stvf_pkg::CFG_SEG_LO: cfg_seg_lo = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // new settings, the extremes often
  task automatic randomize_config();
    logic [63:0] v[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0:       v[i] = '0;
        1:       v[i] = '1;
        default: v[i] = {$urandom, $urandom};
      endcase
    end
    write_reg(stvf_pkg::CFG_TAG, v[0]);
    write_reg(stvf_pkg::CFG_SEG_HI, v[1]);
    write_reg(stvf_pkg::CFG_SEG_LO, v[2]);
    if ($urandom_range(2) == 0) write_reg(CfgIdxUnused, {$urandom, $urandom});
    end_writes();
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // hold off until every beat is taken and every verdict is back
  task automatic wait_drained();
    while (pkt_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // build one packet against the current settings and queue its beats
  task automatic queue_packet(input int len, input fault_e fault, input bit tag_hit,
                              input seg_e seg);
    pkt_beat_t   beat;
    logic [15:0] tag;
    logic [7:0]  b;
    int          near_idx;
    int          k;
    tag      = tag_hit ? cfg_tag : 16'($urandom);
    near_idx = $urandom_range(15);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (fault != FAULT_NOISE) begin
        if (i == stvf_pkg::PosVersion) b[7:4] = stvf_pkg::Ipv6Version;
        if (i == stvf_pkg::PosNextHdr) b = stvf_pkg::NhRouting;
        if (i == stvf_pkg::PosRtType) b = stvf_pkg::RtTypeSrh;
        if (i == stvf_pkg::PosTagHi) b = tag[15:8];
        if (i == stvf_pkg::PosTagLo) b = tag[7:0];
        if (i >= stvf_pkg::PosSegFirst && i < stvf_pkg::PktMinLen) begin
          k = i - stvf_pkg::PosSegFirst;
          if (seg == SEG_MATCH) b = seg_cfg_byte(4'(k));
          if (seg == SEG_NEAR)
            b = seg_cfg_byte(4'(k)) ^
                ((k == near_idx) ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        // header faults
        if (fault == FAULT_VERSION && i == stvf_pkg::PosVersion)
          b[7:4] = stvf_pkg::Ipv6Version ^ 4'($urandom_range(1, 15));
        if (fault == FAULT_NEXT_HDR && i == stvf_pkg::PosNextHdr)
          b = stvf_pkg::NhRouting ^ 8'($urandom_range(1, 255));
        if (fault == FAULT_RT_TYPE && i == stvf_pkg::PosRtType)
          b = stvf_pkg::RtTypeSrh ^ 8'($urandom_range(1, 255));
      end
      beat.data = b;
      beat.last = (i == len - 1);
      pkt_q.push_back(beat);
    end
    bytes_queued += len;
    pkts_queued++;
  endtask

  // mostly well-formed packets, some short, some with bad headers, some noise
  task automatic queue_random_packet();
    int r;
    int len;
    r   = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(71, 150) : $urandom_range(64, 70);
    if (r < 60)
      queue_packet(len, FAULT_NONE, $urandom_range(2) == 0, seg_e'($urandom_range(2)));
    else if (r < 75)
      queue_packet($urandom_range(1, 63), FAULT_NONE, 1'b1, SEG_MATCH);
    else if (r < 87)
      queue_packet(len, fault_e'($urandom_range(1, 3)), 1'b1, SEG_MATCH);
    else
      queue_packet($urandom_range(1, 100), FAULT_NOISE, 1'b0, SEG_RANDOM);
  endtask

  // stimulus sequence
  initial begin
    int unsigned bytes_goal;
    int unsigned pkts_goal;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, the tag of zero hits
    queue_packet(64, FAULT_NONE, 1'b1, SEG_RANDOM);
    wait_drained();

    // directed: all-ones settings, unused index ignored
    write_reg(stvf_pkg::CFG_TAG, '1);
    write_reg(stvf_pkg::CFG_SEG_HI, '1);
    write_reg(stvf_pkg::CFG_SEG_LO, '1);
    write_reg(CfgIdxUnused, 64'h0123_4567_89ab_cdef);
    end_writes();
    queue_packet(64, FAULT_NONE, 1'b1, SEG_RANDOM);     // tag hit
    queue_packet(64, FAULT_NONE, 1'b0, SEG_MATCH);      // segment hit
    queue_packet(64, FAULT_NONE, 1'b0, SEG_NEAR);       // one segment byte off
    queue_packet(64, FAULT_NONE, 1'b0, SEG_RANDOM);     // neither hits
    queue_packet(64, FAULT_VERSION, 1'b1, SEG_MATCH);
    queue_packet(64, FAULT_NEXT_HDR, 1'b1, SEG_MATCH);
    queue_packet(64, FAULT_RT_TYPE, 1'b1, SEG_MATCH);
    queue_packet(63, FAULT_NONE, 1'b1, SEG_MATCH);      // short by one byte
    queue_packet(1, FAULT_NONE, 1'b1, SEG_MATCH);       // single byte
    queue_packet(130, FAULT_NONE, 1'b1, SEG_MATCH);     // long packet
    queue_packet(40, FAULT_NOISE, 1'b0, SEG_RANDOM);
    wait_drained();

    // directed: zero segment, tag from the low bits of a wide write
    write_reg(stvf_pkg::CFG_TAG, 64'hffff_ffff_ffff_0000);
    write_reg(stvf_pkg::CFG_SEG_HI, '0);
    write_reg(stvf_pkg::CFG_SEG_LO, '0);
    end_writes();
    queue_packet(64, FAULT_NONE, 1'b1, SEG_RANDOM);
    queue_packet(64, FAULT_NONE, 1'b0, SEG_MATCH);
    queue_packet(64, FAULT_NONE, 1'b0, SEG_NEAR);

    // random phases: three idle patterns, three settings each
    for (int phase = 0; phase < 9; phase++) begin
      wait_drained();
      randomize_config();
      if (phase == 3) set_idle(80, 38);
      if (phase == 6) set_idle(0, 0);
      if (phase == 7) begin
        // long receiver hold while short packets keep coming
        @(posedge clk_i);
        stall_token <= stall_token + 1;
        for (int i = 0; i < 24; i++)
          queue_packet($urandom_range(1, 6), FAULT_NONE, 1'b1, SEG_MATCH);
      end
      bytes_goal = bytes_queued + 40;
      pkts_goal  = pkts_queued + 1;
      while (bytes_queued < bytes_goal || pkts_queued < pkts_goal)
        queue_random_packet();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("run covered %0d packet bytes, %0d verdicts (%0d drop), %0d register writes",
             bytes_sent, verdicts_seen, drops_seen, cfg_writes);
    $display("idle patterns: sender-heavy, receiver-heavy, none; one long output hold");
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
